[rtl/core/spdoc_pkg.sv]
package spdoc_pkg;

   // Fixed field widths of the ports
   localparam int BINS_W     = 13;
   localparam int MAG_PORT_W = 16;
   localparam int SUM_W      = 29;

   // Parameter defaults
   localparam int MAX_BINS_DEF = 4097;
   localparam int MAG_BITS_DEF = 16;

   // Register reset value and accumulator ceiling
   localparam logic [BINS_W-1:0] BINS_RESET = 13'd1025;
   localparam logic [SUM_W-1:0]  SUM_MAX    = 29'h1FFF_FFFF;

   // Command codes
   localparam logic CMD_BIN   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

endpackage

[rtl/core/spdoc_ram.sv]
module spdoc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4097
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/core/spectral_difference_onset_curve_core.sv]
// Spectral difference onset curve.
// Input channel req_ (valid/ready): req_cmd selects a magnitude bin (CMD_BIN)
// or a history clear (CMD_CLEAR); req_magnitude carries the bin magnitude,
// of which the low MAG_BITS bits are used.
// Result channel rsp_ (valid/ready): one rsp_curve_value per completed frame,
// the saturating sum of floor(sqrt(|mag^2 - previous mag^2|)) over its bins.
// Configuration: csr_write_enable/csr_write_data set bins_per_frame (clamped
// to 1..MAX_BINS) and clear the history, as a clear command does.
// Steps of a magnitude bin: accept, square and history read, difference
// and history write, MAG_BITS iterations of the one-bit-per-cycle square
// root unit, then accumulate. A clear command is handled in the accept
// step. The frame's result is registered in the cycle after its last
// bin's accumulate step.
// The history is a RAM with one write and one read port, tracked by a fill
// count, so reset and clears take effect at once; no clearing pass is run.
// If the receiver stalls, the next frame is still processed; only its last
// bin waits in the accumulate step until the held result is taken.
// Reset (synchronous, active high) clears the history, frame position and
// sum, and sets bins_per_frame to 1025.
module spectral_difference_onset_curve_core
   import spdoc_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEF,
   parameter int MAG_BITS = MAG_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_cmd,
   input  logic [MAG_PORT_W-1:0] req_magnitude,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SUM_W-1:0]      rsp_curve_value,
   input  logic                  csr_write_enable,
   input  logic [BINS_W-1:0]     csr_write_data
);

   localparam int POS_W  = $clog2(MAX_BINS);
   localparam int FILL_W = $clog2(MAX_BINS + 1);
   localparam int PWR_W  = 2 * MAG_BITS;
   localparam int REM_W  = MAG_BITS + 2;
   localparam int CNT_W  = (MAG_BITS > 1) ? $clog2(MAG_BITS) : 1;
   localparam int ACC_W  = ((MAG_BITS > SUM_W) ? MAG_BITS : SUM_W) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIFF,
      ST_ROOT,
      ST_ACC
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [BINS_W-1:0]  bins_ff, bins_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_value_ff, rsp_value_in;

   logic [MAG_BITS-1:0] mag_ff, mag_in;
   logic [PWR_W-1:0]    power_ff, power_in;
   logic [PWR_W-1:0]    old_ff, old_in;
   logic [PWR_W-1:0]    v_ff, v_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [MAG_BITS-1:0] root_ff, root_in;

   logic [PWR_W-1:0]  ram_rd_data;
   logic              ram_rd_en;
   logic              ram_wr_en;
   logic [PWR_W-1:0]  square;
   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;
   logic              take;
   logic [ACC_W-1:0]  acc_sum;
   logic [SUM_W-1:0]  acc_sat;
   logic [FILL_W-1:0] frame_len;
   logic              frame_last;

   // History of squared magnitudes, one entry per bin
   spdoc_ram #(
      .WIDTH (PWR_W),
      .DEPTH (MAX_BINS)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (power_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_value = rsp_value_ff;
   assign ram_rd_en       = req_valid && req_ready && (req_cmd == CMD_BIN);
   assign ram_wr_en       = (state_ff == ST_DIFF);

   // Squarer, registered before use
   assign square = PWR_W'(mag_ff) * PWR_W'(mag_ff);

   // One step of the restoring square root
   assign rem_shift = {rem_ff[MAG_BITS-1:0], v_ff[PWR_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign take      = (rem_shift >= trial);

   // Saturating accumulate
   assign acc_sum = ACC_W'(sum_ff) + ACC_W'(root_ff);
   assign acc_sat = (acc_sum > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];

   // Effective frame length, clamped to 1..MAX_BINS
   always_comb begin
      priority if (bins_ff == '0) begin
         frame_len = FILL_W'(1);
      end else if (32'(bins_ff) > 32'(MAX_BINS)) begin
         frame_len = FILL_W'(MAX_BINS);
      end else begin
         frame_len = FILL_W'(bins_ff);
      end
   end

   assign frame_last = ((FILL_W'(pos_ff) + FILL_W'(1)) >= frame_len);

   // Sequencer and next-value logic
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      bins_in      = bins_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      mag_in       = mag_ff;
      power_in     = power_ff;
      old_in       = old_ff;
      v_in         = v_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_CLEAR) begin
                  pos_in  = '0;
                  fill_in = '0;
                  sum_in  = '0;
               end else begin
                  mag_in   = MAG_BITS'(req_magnitude);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            power_in = square;
            // entries not written since the last clear read as zero
            old_in   = (FILL_W'(pos_ff) < fill_ff) ? ram_rd_data : '0;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            v_in     = (power_ff >= old_ff) ? (power_ff - old_ff) : (old_ff - power_ff);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            if (FILL_W'(pos_ff) == fill_ff) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            v_in    = {v_ff[PWR_W-3:0], 2'b00};
            rem_in  = take ? (rem_shift - trial) : rem_shift;
            root_in = {root_ff[MAG_BITS-2:0], take};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAG_BITS - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (!frame_last) begin
               sum_in   = acc_sat;
               pos_in   = pos_ff + POS_W'(1);
               state_in = ST_IDLE;
            end else if (!(rsp_valid_ff && !rsp_ready)) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_sat;
               sum_in       = '0;
               pos_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register write: new frame length and a fresh history
      if (csr_write_enable) begin
         bins_in = csr_write_data;
         pos_in  = '0;
         fill_in = '0;
         sum_in  = '0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         bins_ff      <= BINS_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         bins_ff      <= bins_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      mag_ff       <= mag_in;
      power_ff     <= power_in;
      old_ff       <= old_in;
      v_ff         <= v_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
   end

   // The frame position never runs past the written part of the history
   a_pos_within_fill: assert property (@(posedge clock) disable iff (reset)
      FILL_W'(pos_ff) <= fill_ff)
      else $error("frame position beyond history fill count");

   // A result only appears out of the accumulate step
   a_rsp_from_acc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ACC))
      else $error("result raised outside accumulate step");

   // The root unit never runs past MAG_BITS steps
   a_root_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (cnt_ff <= CNT_W'(MAG_BITS - 1)))
      else $error("square root iteration count overrun");

endmodule

[test/spectral_difference_onset_curve_core_tb.sv]
`timescale 1ns / 100ps

module spectral_difference_onset_curve_core_tb;
   import spdoc_pkg::*;

   localparam int SETTLE_CYCLES    = 2 * (MAG_BITS_DEF + 4);
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS     = 880;
   localparam int CYCLE_LIMIT      = 1000000;

   // Expected curve values, worked out from every accepted bin transaction
   class onset_scoreboard;
      logic [31:0]       bin_power [MAX_BINS_DEF];
      logic [SUM_W-1:0]  running_sum;
      int unsigned       position;
      logic [BINS_W-1:0] frame_len_reg;
      logic [SUM_W-1:0]  curve_queue [$];
      int unsigned       errors;

      function void clear_history();
         for (int i = 0; i < MAX_BINS_DEF; i++) begin
            bin_power[i] = '0;
         end
         running_sum = '0;
         position    = 0;
      endfunction

      function void reset_state();
         clear_history();
         frame_len_reg = BINS_RESET;
         curve_queue.delete();
         errors = 0;
      endfunction

      // a register write restarts the history as well
      function void set_frame_length(logic [BINS_W-1:0] bin_count);
         frame_len_reg = bin_count;
         clear_history();
      endfunction

      // zero behaves as one, anything past the store depth as the full depth
      function int unsigned frame_bins();
         if (frame_len_reg == 0) return 1;
         if (frame_len_reg > MAX_BINS_DEF) return MAX_BINS_DEF;
         return 32'(frame_len_reg);
      endfunction

      // floor of the square root, one result bit at a time from the top
      function logic [15:0] floor_sqrt(logic [31:0] v);
         logic [15:0] root;
         logic [31:0] trial;
         root = '0;
         for (int b = 15; b >= 0; b--) begin
            root[b] = 1'b1;
            trial   = 32'(root) * 32'(root);
            if (trial > v) root[b] = 1'b0;
         end
         return root;
      endfunction

      function int unsigned pending();
         return curve_queue.size();
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns mismatch: %s", $time, msg);
         errors++;
      endtask

      function void note_input(logic cmd, logic [MAG_PORT_W-1:0] mag);
         logic [31:0]  power;
         logic [31:0]  prior;
         logic [31:0]  spread;
         logic [SUM_W:0] total;
         if (cmd == CMD_CLEAR) begin
            clear_history();
            return;
         end
         power  = 32'(mag) * 32'(mag);
         prior  = bin_power[position];
         spread = (power >= prior) ? power - prior : prior - power;
         total  = {1'b0, running_sum} + (SUM_W + 1)'(floor_sqrt(spread));
         running_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
         bin_power[position] = power;
         position++;
         // frame complete: one curve value out
         if (position >= frame_bins()) begin
            curve_queue.push_back(running_sum);
            running_sum = '0;
            position    = 0;
         end
      endfunction

      task check_result(logic [SUM_W-1:0] got);
         logic [SUM_W-1:0] want;
         if (curve_queue.size() == 0) begin
            report_mismatch($sformatf("curve value %0d with none expected", got));
            return;
         end
         want = curve_queue.pop_front();
         if (got !== want)
            report_mismatch($sformatf("curve value %0d, expected %0d", got, want));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_cmd;
   logic [MAG_PORT_W-1:0] req_magnitude;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [SUM_W-1:0]      rsp_curve_value;
   logic                  csr_write_enable;
   logic [BINS_W-1:0]     csr_write_data;

   onset_scoreboard       sb;
   bit                    idle_on;
   bit                    hold_results;
   logic [MAG_PORT_W-1:0] last_magnitude;
   int                    cycle_count;

   spectral_difference_onset_curve_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_magnitude    (req_magnitude),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_curve_value  (rsp_curve_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("spectral_difference_onset_curve_core_tb: FAIL");
         $finish;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_curve_value);
   end

   // Result side: random stall bursts, plus one long hold-off on request
   initial begin : result_drain
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 6);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Magnitudes biased towards the extremes and towards small differences
   function automatic logic [MAG_PORT_W-1:0] pick_magnitude();
      case ($urandom_range(0, 7))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2: return 16'($urandom_range(0, 255));
         3: return 16'($urandom_range(16'hFF00, 16'hFFFF));
         4: return last_magnitude ^ 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   // One input transaction, then perhaps a gap
   task automatic feed(input logic cmd, input logic [MAG_PORT_W-1:0] mag);
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_magnitude <= mag;
      do @(posedge clock); while (!req_ready);
      sb.note_input(cmd, mag);
      last_magnitude = mag;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Drain, let the last bin finish, then write the frame length
   task automatic reconfigure(input logic [BINS_W-1:0] bin_count);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= bin_count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_frame_length(bin_count);
   endtask

   task automatic random_phase(input int unsigned items);
      int unsigned pause_at;
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, items - 1) : items;
      for (int unsigned k = 0; k < items; k++) begin
         // sender waits for every outstanding curve value
         if (k == pause_at) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
         if ($urandom_range(0, 29) == 0) feed(CMD_CLEAR, 16'($urandom));
         else feed(CMD_BIN, pick_magnitude());
      end
   endtask

   initial begin : stimulus
      int unsigned random_items;
      int unsigned items;
      logic [BINS_W-1:0] bin_count;

      sb = new();
      sb.reset_state();
      idle_on          = 1'b1;
      hold_results     = 1'b0;
      last_magnitude   = '0;
      random_items     = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= CMD_BIN;
      req_magnitude    <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Frame length from reset, with a clear early on: no frame completes
      repeat (10) feed(CMD_BIN, pick_magnitude());
      feed(CMD_CLEAR, 16'hFFFF);
      repeat (40) feed(CMD_BIN, pick_magnitude());

      // Directed: two-bin frames with extreme magnitudes
      reconfigure(13'd2);
      feed(CMD_BIN, 16'hFFFF);
      feed(CMD_BIN, 16'h0000);
      feed(CMD_BIN, 16'h0000);
      feed(CMD_BIN, 16'hFFFF);
      feed(CMD_BIN, 16'hFFFF);
      feed(CMD_BIN, 16'hFFFF);
      feed(CMD_BIN, 16'hFFFF);
      feed(CMD_BIN, 16'hFFFF);
      // clear in mid-frame drops the partial sum and the history
      feed(CMD_BIN, 16'h1234);
      feed(CMD_CLEAR, 16'hFFFF);
      feed(CMD_BIN, 16'h0001);
      feed(CMD_BIN, 16'h0002);
      feed(CMD_BIN, 16'h8000);
      feed(CMD_BIN, 16'h7FFF);
      feed(CMD_BIN, 16'h00FF);
      feed(CMD_BIN, 16'h0100);
      // one-bin frames, and zero acting as one
      reconfigure(13'd1);
      feed(CMD_BIN, 16'hAAAA);
      feed(CMD_BIN, 16'h5555);
      feed(CMD_CLEAR, 16'h0000);
      feed(CMD_BIN, 16'h0000);
      reconfigure(13'd0);
      feed(CMD_BIN, 16'hFFFF);
      feed(CMD_BIN, 16'hFFFE);

      // Largest settings: no result before the frame fills
      reconfigure(13'h1FFF);
      repeat (30) feed(CMD_BIN, pick_magnitude());
      reconfigure(13'(MAX_BINS_DEF));
      repeat (30) feed(CMD_BIN, pick_magnitude());

      // Random phases, mostly short frames
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       bin_count = 13'd0;
            1:       bin_count = 13'd1;
            2:       bin_count = 13'($urandom_range(2, 4));
            7, 8:    bin_count = 13'($urandom_range(17, 64));
            9:       bin_count = 13'($urandom_range(65, 300));
            default: bin_count = 13'($urandom_range(1, 16));
         endcase
         reconfigure(bin_count);
         idle_on = ($urandom_range(0, 3) != 0);
         items = $urandom_range(20, 100);
         random_phase(items);
         random_items += items;
      end

      // Hold the result side off while bins keep coming: the block backs up
      reconfigure(13'd1);
      idle_on      = 1'b0;
      hold_results = 1'b1;
      repeat (48) feed(CMD_BIN, pick_magnitude());

      // Closing stretch at full rate on both sides
      reconfigure(13'($urandom_range(1, 8)));
      random_phase(60);

      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("spectral_difference_onset_curve_core_tb: PASS");
      end else begin
         $display("spectral_difference_onset_curve_core_tb: FAIL");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/spdoc_pkg.sv
rtl/core/spdoc_ram.sv
rtl/core/spectral_difference_onset_curve_core.sv
test/spectral_difference_onset_curve_core_tb.sv
